[hw/rtl/sdp_pkg.sv]
// Shared types, codes and defaults of the SMS-DELIVER PDU field parser.
package sdp_pkg;

    // Register reset values and limits.
    localparam logic [7:0] EXPECTED_CODING_RST    = 8'h04;
    localparam logic [3:0] MAX_CENTER_OCTETS_RST  = 4'd7;
    localparam logic [4:0] MAX_ADDRESS_DIGITS_RST = 5'd12;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPECTED_CODING    = 2'd0;
    localparam logic [1:0] CFG_MAX_CENTER_OCTETS  = 2'd1;
    localparam logic [1:0] CFG_MAX_ADDRESS_DIGITS = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Default depth of the result queue.
    localparam int RES_FIFO_DEPTH = 4;

    localparam logic [7:0] TS_OCTETS  = 8'd7;
    localparam logic [3:0] NIBBLE_F   = 4'hF;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    typedef enum logic [3:0] {
        KIND_CENTER_LEN   = 4'd0,
        KIND_CENTER_TYPE  = 4'd1,
        KIND_CENTER_DIGIT = 4'd2,
        KIND_FIRST_OCTET  = 4'd3,
        KIND_ADDR_LEN     = 4'd4,
        KIND_ADDR_TYPE    = 4'd5,
        KIND_ADDR_DIGIT   = 4'd6,
        KIND_PID          = 4'd7,
        KIND_DCS          = 4'd8,
        KIND_TIMESTAMP    = 4'd9,
        KIND_UDL          = 4'd10,
        KIND_PAYLOAD      = 4'd11,
        KIND_END          = 4'd12
    } field_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_CENTER_LEN  = 2'd1,
        ERR_ADDRESS_LEN = 2'd2,
        ERR_BAD_DIGIT   = 2'd3
    } error_code_t;

    typedef enum logic [3:0] {
        PH_SCLEN   = 4'd0,
        PH_SCTYPE  = 4'd1,
        PH_SCDIG   = 4'd2,
        PH_FO      = 4'd3,
        PH_OALEN   = 4'd4,
        PH_OATYPE  = 4'd5,
        PH_OADIG   = 4'd6,
        PH_PID     = 4'd7,
        PH_DCS     = 4'd8,
        PH_TS      = 4'd9,
        PH_UDL     = 4'd10,
        PH_UDHL    = 4'd11,
        PH_HSKIP   = 4'd12,
        PH_PAYLOAD = 4'd13,
        PH_SKIP    = 4'd14
    } phase_t;

    typedef struct packed {
        logic [3:0] field_kind;
        logic [7:0] field_value;
        logic [4:0] digit_position;
        logic [1:0] error_code;
        logic       coding_matches;
        logic       last;
    } result_t;

    function automatic result_t make_result(input field_kind_t kind, input logic [7:0] value,
                                            input logic [4:0] pos, input error_code_t err,
                                            input logic coding);
        result_t r;
        r.field_kind     = kind;
        r.field_value    = value;
        r.digit_position = pos;
        r.error_code     = err;
        r.coding_matches = coding;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/sdp_ifs.sv]
// Stream interfaces for PDU bytes in and parsed fields out.
interface sdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pdu_byte;
    logic       end_of_pdu;

    modport source (output valid, output pdu_byte, output end_of_pdu, input ready);
    modport sink   (input valid, input pdu_byte, input end_of_pdu, output ready);
endinterface

interface sdp_field_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_kind;
    logic [7:0] field_value;
    logic [4:0] digit_position;
    logic [1:0] error_code;
    logic       coding_matches;
    logic       last;

    modport source (output valid, output field_kind, output field_value,
                    output digit_position, output error_code, output coding_matches,
                    output last, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input digit_position, input error_code, input coding_matches,
                    input last, output ready);
endinterface

[hw/rtl/sms_deliver_pdu_field_parser_core.sv]
// SMS-DELIVER PDU field parser: byte stream in, field results out.
//
//   channel     dir   payload                                    transaction
//   ---------   ---   ----------------------------------------   ----------------
//   pdu_in      in    pdu_byte[7:0], end_of_pdu                  valid & ready
//   field_out   out   field_kind, field_value, digit_position,   valid & ready
//                     error_code, coding_matches, last
//   cfg         in    cfg_we, cfg_index[1:0], cfg_data[7:0]       cfg_we
//
// Each accepted byte is parsed in the cycle it is taken: the phase registers
// update at that edge and its zero to two results drop into a small result
// queue, so a byte can be taken every cycle while the queue has room. Output
// drains one result per cycle while field_out.ready is high. pdu_in.ready is
// high while the queue has room for two results, the most that one byte gives,
// which keeps the input side independent of field_out.ready.
// Reset clears the phase state, the queue and restores register defaults.
module sms_deliver_pdu_field_parser_core #(
    parameter int FIFO_DEPTH = sdp_pkg::RES_FIFO_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sdp_byte_if.sink                      pdu_in,
    sdp_field_if.source                   field_out,
    input  logic                          cfg_we,
    input  logic [sdp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic [7:0] expected_coding_reg;
    logic [3:0] max_center_octets_reg;
    logic [4:0] max_address_digits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_coding_reg    <= sdp_pkg::EXPECTED_CODING_RST;
            max_center_octets_reg  <= sdp_pkg::MAX_CENTER_OCTETS_RST;
            max_address_digits_reg <= sdp_pkg::MAX_ADDRESS_DIGITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdp_pkg::CFG_EXPECTED_CODING:    expected_coding_reg    <= cfg_data;
                sdp_pkg::CFG_MAX_CENTER_OCTETS:  max_center_octets_reg  <= cfg_data[3:0];
                sdp_pkg::CFG_MAX_ADDRESS_DIGITS: max_address_digits_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Parser state.
    sdp_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]           bytes_left_reg, bytes_left_next;
    logic [4:0]           digit_count_reg, digit_count_next;
    logic                 header_flag_reg, header_flag_next;
    logic [7:0]           header_skip_reg, header_skip_next;
    logic                 coding_flag_reg, coding_flag_next;
    sdp_pkg::error_code_t error_latch_reg, error_latch_next;

    // Results of the byte at the input.
    sdp_pkg::result_t res0, res1;
    logic [1:0]       res_count;

    logic       in_accept;
    logic [7:0] b;
    logic [3:0] lo_nib, hi_nib;
    logic       digit_bad;
    logic [4:0] dc_plus1;
    logic [7:0] bl_minus1;
    logic [7:0] hs_minus1;
    logic [8:0] addr_octets;

    assign b           = pdu_in.pdu_byte;
    assign lo_nib      = b[3:0];
    assign hi_nib      = b[7:4];
    assign digit_bad   = (lo_nib > sdp_pkg::DIGIT_MAX) ||
                         ((hi_nib > sdp_pkg::DIGIT_MAX) && (hi_nib != sdp_pkg::NIBBLE_F));
    assign dc_plus1    = digit_count_reg + 5'd1;
    assign bl_minus1   = bytes_left_reg - 8'd1;
    assign hs_minus1   = header_skip_reg - 8'd1;
    assign addr_octets = ({1'b0, b} + 9'd1) >> 1;

    always_comb
    begin
        sdp_pkg::field_kind_t dkind;
        sdp_pkg::phase_t      dnext;

        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        digit_count_next = digit_count_reg;
        header_flag_next = header_flag_reg;
        header_skip_next = header_skip_reg;
        coding_flag_next = coding_flag_reg;
        error_latch_next = error_latch_reg;
        res_count        = 2'd0;
        res0             = '0;
        res1             = '0;

        dkind = (phase_reg == sdp_pkg::PH_SCDIG) ? sdp_pkg::KIND_CENTER_DIGIT
                                                 : sdp_pkg::KIND_ADDR_DIGIT;
        dnext = (phase_reg == sdp_pkg::PH_SCDIG) ? sdp_pkg::PH_FO : sdp_pkg::PH_PID;

        case (phase_reg)
            sdp_pkg::PH_SCLEN:
            begin
                digit_count_next = 5'd0;
                res_count        = 2'd1;
                if (b == 8'd0)
                begin
                    phase_next = sdp_pkg::PH_FO;
                end
                else if (b > {4'd0, max_center_octets_reg})
                begin
                    error_latch_next = sdp_pkg::ERR_CENTER_LEN;
                    phase_next       = sdp_pkg::PH_SKIP;
                end
                else
                begin
                    bytes_left_next = b - 8'd1;
                    phase_next      = sdp_pkg::PH_SCTYPE;
                end
                res0 = sdp_pkg::make_result(sdp_pkg::KIND_CENTER_LEN, b, 5'd0,
                                            error_latch_next, coding_flag_reg);
            end
            sdp_pkg::PH_SCTYPE:
            begin
                res_count  = 2'd1;
                res0       = sdp_pkg::make_result(sdp_pkg::KIND_CENTER_TYPE, b, 5'd0,
                                                  error_latch_reg, coding_flag_reg);
                phase_next = (bytes_left_reg == 8'd0) ? sdp_pkg::PH_FO : sdp_pkg::PH_SCDIG;
            end
            sdp_pkg::PH_SCDIG, sdp_pkg::PH_OADIG:
            begin
                if (digit_bad)
                begin
                    // Report the raw octet once, then drop the rest of the PDU.
                    error_latch_next = sdp_pkg::ERR_BAD_DIGIT;
                    res_count        = 2'd1;
                    res0             = sdp_pkg::make_result(dkind, b, digit_count_reg,
                                                            sdp_pkg::ERR_BAD_DIGIT,
                                                            coding_flag_reg);
                    phase_next       = sdp_pkg::PH_SKIP;
                end
                else
                begin
                    res0 = sdp_pkg::make_result(dkind, {4'd0, lo_nib}, digit_count_reg,
                                                error_latch_reg, coding_flag_reg);
                    res1 = sdp_pkg::make_result(dkind, {4'd0, hi_nib}, dc_plus1,
                                                error_latch_reg, coding_flag_reg);
                    // A high nibble of F is filler and yields no digit.
                    if (hi_nib == sdp_pkg::NIBBLE_F)
                    begin
                        res_count        = 2'd1;
                        digit_count_next = dc_plus1;
                    end
                    else
                    begin
                        res_count        = 2'd2;
                        digit_count_next = digit_count_reg + 5'd2;
                    end
                    bytes_left_next = bl_minus1;
                    if (bl_minus1 == 8'd0)
                        phase_next = dnext;
                end
            end
            sdp_pkg::PH_FO:
            begin
                res_count        = 2'd1;
                res0             = sdp_pkg::make_result(sdp_pkg::KIND_FIRST_OCTET, b, 5'd0,
                                                        error_latch_reg, coding_flag_reg);
                header_flag_next = b[6];
                phase_next       = sdp_pkg::PH_OALEN;
            end
            sdp_pkg::PH_OALEN:
            begin
                digit_count_next = 5'd0;
                res_count        = 2'd1;
                if (b > {3'd0, max_address_digits_reg})
                begin
                    error_latch_next = sdp_pkg::ERR_ADDRESS_LEN;
                    phase_next       = sdp_pkg::PH_SKIP;
                end
                else
                begin
                    bytes_left_next = addr_octets[7:0];
                    phase_next      = sdp_pkg::PH_OATYPE;
                end
                res0 = sdp_pkg::make_result(sdp_pkg::KIND_ADDR_LEN, b, 5'd0,
                                            error_latch_next, coding_flag_reg);
            end
            sdp_pkg::PH_OATYPE:
            begin
                res_count  = 2'd1;
                res0       = sdp_pkg::make_result(sdp_pkg::KIND_ADDR_TYPE, b, 5'd0,
                                                  error_latch_reg, coding_flag_reg);
                phase_next = (bytes_left_reg == 8'd0) ? sdp_pkg::PH_PID : sdp_pkg::PH_OADIG;
            end
            sdp_pkg::PH_PID:
            begin
                res_count  = 2'd1;
                res0       = sdp_pkg::make_result(sdp_pkg::KIND_PID, b, 5'd0,
                                                  error_latch_reg, coding_flag_reg);
                phase_next = sdp_pkg::PH_DCS;
            end
            sdp_pkg::PH_DCS:
            begin
                coding_flag_next = (b == expected_coding_reg);
                res_count        = 2'd1;
                res0             = sdp_pkg::make_result(sdp_pkg::KIND_DCS, b, 5'd0,
                                                        error_latch_reg, coding_flag_next);
                bytes_left_next  = sdp_pkg::TS_OCTETS;
                phase_next       = sdp_pkg::PH_TS;
            end
            sdp_pkg::PH_TS:
            begin
                res_count       = 2'd1;
                res0            = sdp_pkg::make_result(sdp_pkg::KIND_TIMESTAMP, b, 5'd0,
                                                       error_latch_reg, coding_flag_reg);
                bytes_left_next = bl_minus1;
                if (bl_minus1 == 8'd0)
                    phase_next = sdp_pkg::PH_UDL;
            end
            sdp_pkg::PH_UDL:
            begin
                if (header_flag_reg)
                begin
                    // Hold UDL until the header length arrives.
                    bytes_left_next = b;
                    phase_next      = sdp_pkg::PH_UDHL;
                end
                else
                begin
                    res_count  = 2'd1;
                    res0       = sdp_pkg::make_result(sdp_pkg::KIND_UDL, b, 5'd0,
                                                      error_latch_reg, coding_flag_reg);
                    phase_next = sdp_pkg::PH_PAYLOAD;
                end
            end
            sdp_pkg::PH_UDHL:
            begin
                res_count        = 2'd1;
                res0             = sdp_pkg::make_result(sdp_pkg::KIND_UDL,
                                       (bytes_left_reg > b) ? (bytes_left_reg - b - 8'd1)
                                                            : 8'd0,
                                       5'd0, error_latch_reg, coding_flag_reg);
                header_skip_next = b;
                phase_next       = (b == 8'd0) ? sdp_pkg::PH_PAYLOAD : sdp_pkg::PH_HSKIP;
            end
            sdp_pkg::PH_HSKIP:
            begin
                header_skip_next = hs_minus1;
                if (hs_minus1 == 8'd0)
                    phase_next = sdp_pkg::PH_PAYLOAD;
            end
            sdp_pkg::PH_PAYLOAD:
            begin
                res_count = 2'd1;
                res0      = sdp_pkg::make_result(sdp_pkg::KIND_PAYLOAD, b, 5'd0,
                                                 error_latch_reg, coding_flag_reg);
            end
            default:
            begin
                phase_next = sdp_pkg::PH_SKIP;
            end
        endcase

        if (pdu_in.end_of_pdu)
        begin
            // Close the PDU: flag the final result, emit an end marker if silent.
            case (res_count)
                2'd0:
                begin
                    res_count = 2'd1;
                    res0      = sdp_pkg::make_result(sdp_pkg::KIND_END, 8'd0, 5'd0,
                                                     error_latch_next, coding_flag_next);
                    res0.last = 1'b1;
                end
                2'd1:    res0.last = 1'b1;
                default: res1.last = 1'b1;
            endcase
            phase_next       = sdp_pkg::PH_SCLEN;
            bytes_left_next  = 8'd0;
            digit_count_next = 5'd0;
            header_flag_next = 1'b0;
            header_skip_next = 8'd0;
            coding_flag_next = 1'b0;
            error_latch_next = sdp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= sdp_pkg::PH_SCLEN;
            bytes_left_reg  <= 8'd0;
            digit_count_reg <= 5'd0;
            header_flag_reg <= 1'b0;
            header_skip_reg <= 8'd0;
            coding_flag_reg <= 1'b0;
            error_latch_reg <= sdp_pkg::ERR_NONE;
        end
        else if (in_accept)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            digit_count_reg <= digit_count_next;
            header_flag_reg <= header_flag_next;
            header_skip_reg <= header_skip_next;
            coding_flag_reg <= coding_flag_next;
            error_latch_reg <= error_latch_next;
        end
    end

    // Result queue: takes up to two results per transaction, drains one per cycle when ready.
    sdp_pkg::result_t res_q [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_accept;

    assign pdu_in.ready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_accept    = pdu_in.valid && pdu_in.ready;
    assign out_accept   = field_out.valid && field_out.ready;

    assign wr_ptr_p1 = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (in_accept)
        begin
            case (res_count)
                2'd1:    wr_ptr_next = wr_ptr_p1;
                2'd2:    wr_ptr_next = (wr_ptr_p1 == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                             : wr_ptr_p1 + 1'b1;
                default: wr_ptr_next = wr_ptr_reg;
            endcase
        end
        rd_ptr_next = rd_ptr_reg;
        if (out_accept)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + (in_accept ? CNT_W'(res_count) : '0)
                               - (out_accept ? CNT_W'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (res_count != 2'd0))
            res_q[wr_ptr_reg] <= res0;
        if (in_accept && (res_count == 2'd2))
            res_q[wr_ptr_p1] <= res1;
    end

    // Drive the head of the queue.
    assign field_out.valid          = (count_reg != '0);
    assign field_out.field_kind     = res_q[rd_ptr_reg].field_kind;
    assign field_out.field_value    = res_q[rd_ptr_reg].field_value;
    assign field_out.digit_position = res_q[rd_ptr_reg].digit_position;
    assign field_out.error_code     = res_q[rd_ptr_reg].error_code;
    assign field_out.coding_matches = res_q[rd_ptr_reg].coding_matches;
    assign field_out.last           = res_q[rd_ptr_reg].last;

endmodule

[tb/tb_sms_deliver_pdu_field_parser_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the SMS-DELIVER PDU field parser core.
module tb_sms_deliver_pdu_field_parser_core;

    // Run limits and traffic shape.
    localparam int CYCLE_LIMIT  = 100000;
    localparam int IDLE_PCT     = 24;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_OCTETS = 120;

    // One pending input transaction: a raw PDU octet and its end mark.
    typedef struct packed {
        logic [7:0] octet;
        logic       eop;
    } pdu_octet_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sdp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sdp_pkg::CFG_DATA_W-1:0]  cfg_data;

    sdp_byte_if  pdu_in_if ();
    sdp_field_if field_out_if ();

    sms_deliver_pdu_field_parser_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pdu_in    (pdu_in_if),
        .field_out (field_out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Octets waiting for the driver, and fields the parser still owes us.
    pdu_octet_t       octet_q[$];
    sdp_pkg::result_t field_expect_q[$];
    int unsigned      queued_cnt;
    int unsigned      taken_cnt;
    int unsigned      cycle_cnt;
    logic             took_octet;
    logic             steady;
    logic             failed;

    // Shadow copies of the configuration registers.
    logic [7:0] coding_ref;
    logic [3:0] center_max_ref;
    logic [4:0] addr_max_ref;

    // Shadow parse state, one PDU at a time.
    sdp_pkg::phase_t      pstate;
    logic [7:0]           octets_left;
    logic [4:0]           digit_idx;
    logic                 udhi;
    logic [7:0]           udh_left;
    logic                 dcs_hit;
    sdp_pkg::error_code_t err_latch;

    // ------------------------------------------------------------------
    // Field predictor
    // ------------------------------------------------------------------

    // Drop all per-PDU state; the registers are kept.
    function automatic void clear_frame();
        pstate      = sdp_pkg::PH_SCLEN;
        octets_left = '0;
        digit_idx   = '0;
        udhi        = 1'b0;
        udh_left    = '0;
        dcs_hit     = 1'b0;
        err_latch   = sdp_pkg::ERR_NONE;
    endfunction

    // Queue one expected field; error and coding flags are the ones latched so far.
    function automatic void note_field(input sdp_pkg::field_kind_t kind,
                                       input logic [7:0] value, input logic [4:0] pos);
        sdp_pkg::result_t r;
        r.field_kind     = kind;
        r.field_value    = value;
        r.digit_position = pos;
        r.error_code     = err_latch;
        r.coding_matches = dcs_hit;
        r.last           = 1'b0;
        field_expect_q.push_back(r);
    endfunction

    // One semi-octet pair: low nibble first, a high nibble of F is filler.
    function automatic void parse_digits(input sdp_pkg::field_kind_t kind, input logic [7:0] b,
                                         input sdp_pkg::phase_t next_ph);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = b[3:0];
        hi = b[7:4];
        if (lo > sdp_pkg::DIGIT_MAX || (hi > sdp_pkg::DIGIT_MAX && hi != sdp_pkg::NIBBLE_F))
        begin
            // Report the raw octet once, then ignore the rest of the PDU.
            err_latch = sdp_pkg::ERR_BAD_DIGIT;
            note_field(kind, b, digit_idx);
            pstate = sdp_pkg::PH_SKIP;
            return;
        end
        note_field(kind, {4'd0, lo}, digit_idx);
        digit_idx = digit_idx + 5'd1;
        if (hi != sdp_pkg::NIBBLE_F)
        begin
            note_field(kind, {4'd0, hi}, digit_idx);
            digit_idx = digit_idx + 5'd1;
        end
        octets_left = octets_left - 8'd1;
        if (octets_left == 8'd0)
            pstate = next_ph;
    endfunction

    // Advance the shadow parser by one accepted octet and queue its fields.
    function automatic void parse_octet(input logic [7:0] b, input logic eop);
        int unsigned      before_cnt;
        logic [7:0]       adj;
        sdp_pkg::result_t tail;
        before_cnt = field_expect_q.size();
        case (pstate)
            sdp_pkg::PH_SCLEN:
            begin
                digit_idx = '0;
                if (b == 8'd0)
                begin
                    // Absent service centre: go straight to the first octet.
                    note_field(sdp_pkg::KIND_CENTER_LEN, b, '0);
                    pstate = sdp_pkg::PH_FO;
                end
                else if (b > {4'd0, center_max_ref})
                begin
                    err_latch = sdp_pkg::ERR_CENTER_LEN;
                    note_field(sdp_pkg::KIND_CENTER_LEN, b, '0);
                    pstate = sdp_pkg::PH_SKIP;
                end
                else
                begin
                    note_field(sdp_pkg::KIND_CENTER_LEN, b, '0);
                    octets_left = b - 8'd1;
                    pstate = sdp_pkg::PH_SCTYPE;
                end
            end
            sdp_pkg::PH_SCTYPE:
            begin
                note_field(sdp_pkg::KIND_CENTER_TYPE, b, '0);
                pstate = (octets_left == 8'd0) ? sdp_pkg::PH_FO : sdp_pkg::PH_SCDIG;
            end
            sdp_pkg::PH_SCDIG:
                parse_digits(sdp_pkg::KIND_CENTER_DIGIT, b, sdp_pkg::PH_FO);
            sdp_pkg::PH_FO:
            begin
                note_field(sdp_pkg::KIND_FIRST_OCTET, b, '0);
                udhi = b[6];
                pstate = sdp_pkg::PH_OALEN;
            end
            sdp_pkg::PH_OALEN:
            begin
                digit_idx = '0;
                if (b > {3'd0, addr_max_ref})
                begin
                    err_latch = sdp_pkg::ERR_ADDRESS_LEN;
                    note_field(sdp_pkg::KIND_ADDR_LEN, b, '0);
                    pstate = sdp_pkg::PH_SKIP;
                end
                else
                begin
                    // Length counts digits; round odd counts up to whole octets.
                    note_field(sdp_pkg::KIND_ADDR_LEN, b, '0);
                    octets_left = (b + 8'd1) >> 1;
                    pstate = sdp_pkg::PH_OATYPE;
                end
            end
            sdp_pkg::PH_OATYPE:
            begin
                note_field(sdp_pkg::KIND_ADDR_TYPE, b, '0);
                pstate = (octets_left == 8'd0) ? sdp_pkg::PH_PID : sdp_pkg::PH_OADIG;
            end
            sdp_pkg::PH_OADIG:
                parse_digits(sdp_pkg::KIND_ADDR_DIGIT, b, sdp_pkg::PH_PID);
            sdp_pkg::PH_PID:
            begin
                note_field(sdp_pkg::KIND_PID, b, '0);
                pstate = sdp_pkg::PH_DCS;
            end
            sdp_pkg::PH_DCS:
            begin
                dcs_hit = (b == coding_ref);
                note_field(sdp_pkg::KIND_DCS, b, '0);
                octets_left = sdp_pkg::TS_OCTETS;
                pstate = sdp_pkg::PH_TS;
            end
            sdp_pkg::PH_TS:
            begin
                note_field(sdp_pkg::KIND_TIMESTAMP, b, '0);
                octets_left = octets_left - 8'd1;
                if (octets_left == 8'd0)
                    pstate = sdp_pkg::PH_UDL;
            end
            sdp_pkg::PH_UDL:
            begin
                // With a header, hold UDL back until the header length is known.
                if (udhi)
                begin
                    octets_left = b;
                    pstate = sdp_pkg::PH_UDHL;
                end
                else
                begin
                    note_field(sdp_pkg::KIND_UDL, b, '0);
                    pstate = sdp_pkg::PH_PAYLOAD;
                end
            end
            sdp_pkg::PH_UDHL:
            begin
                adj = (octets_left > b) ? octets_left - b - 8'd1 : 8'd0;
                note_field(sdp_pkg::KIND_UDL, adj, '0);
                udh_left = b;
                pstate = (b == 8'd0) ? sdp_pkg::PH_PAYLOAD : sdp_pkg::PH_HSKIP;
            end
            sdp_pkg::PH_HSKIP:
            begin
                udh_left = udh_left - 8'd1;
                if (udh_left == 8'd0)
                    pstate = sdp_pkg::PH_PAYLOAD;
            end
            sdp_pkg::PH_PAYLOAD:
                note_field(sdp_pkg::KIND_PAYLOAD, b, '0);
            default:
                pstate = sdp_pkg::PH_SKIP;
        endcase

        if (eop)
        begin
            // A silent octet still closes the PDU with an end field.
            if (field_expect_q.size() == before_cnt)
                note_field(sdp_pkg::KIND_END, 8'd0, '0);
            tail = field_expect_q.pop_back();
            tail.last = 1'b1;
            field_expect_q.push_back(tail);
            clear_frame();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_octet(input logic [7:0] b, input logic eop);
        pdu_octet_t t;
        t.octet = b;
        t.eop   = eop;
        octet_q.push_back(t);
        queued_cnt++;
    endfunction

    // Queue the first cut octets of a frame; the last one carries the end mark.
    function automatic void send_frame(input logic [7:0] frame[$], input int unsigned cut);
        for (int i = 0; i < cut; i++)
            push_octet(frame[i], i == cut - 1);
    endfunction

    // A semi-octet pair, mostly legal BCD with some filler, rarely a bad digit.
    function automatic logic [7:0] bcd_octet();
        logic [3:0] lo;
        logic [3:0] hi;
        if ($urandom_range(0, 24) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                lo = 4'($urandom_range(10, 15));
                hi = 4'($urandom_range(0, 15));
            end
            else
            begin
                lo = 4'($urandom_range(0, 9));
                hi = 4'($urandom_range(10, 14));
            end
        end
        else
        begin
            lo = 4'($urandom_range(0, 9));
            hi = ($urandom_range(0, 4) == 0) ? sdp_pkg::NIBBLE_F : 4'($urandom_range(0, 9));
        end
        return {hi, lo};
    endfunction

    function automatic logic [7:0] rand_octet();
        return 8'($urandom_range(0, 255));
    endfunction

    // Build one PDU against the current register settings, now and then
    // with a bad length or cut short by an early end mark.
    function automatic void queue_pdu();
        logic [7:0]  frame[$];
        logic [7:0]  first_oct;
        int unsigned pick;
        int unsigned sc_len;
        int unsigned oa_len;
        int unsigned hdr_len;
        int unsigned cut;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            sc_len = 0;
        else if (pick == 1)
            sc_len = $urandom_range(center_max_ref + 1, 255);
        else
            sc_len = (center_max_ref == 0) ? 0 : $urandom_range(1, center_max_ref);
        frame.push_back(8'(sc_len));
        if (sc_len > 0 && sc_len <= center_max_ref)
        begin
            frame.push_back(rand_octet());
            repeat (sc_len - 1) frame.push_back(bcd_octet());
        end

        first_oct = rand_octet();
        frame.push_back(first_oct);

        if ($urandom_range(0, 11) == 0)
            oa_len = $urandom_range(addr_max_ref + 1, 255);
        else
            oa_len = $urandom_range(0, addr_max_ref);
        frame.push_back(8'(oa_len));
        if (oa_len <= addr_max_ref)
        begin
            frame.push_back(rand_octet());
            repeat ((oa_len + 1) / 2) frame.push_back(bcd_octet());
        end

        frame.push_back(rand_octet());
        frame.push_back(($urandom_range(0, 2) == 0) ? coding_ref : rand_octet());
        repeat (7) frame.push_back(rand_octet());
        frame.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20)) : rand_octet());
        if (first_oct[6])
        begin
            hdr_len = $urandom_range(0, 5);
            frame.push_back(8'(hdr_len));
            repeat (hdr_len) frame.push_back(rand_octet());
        end
        repeat ($urandom_range(0, 6)) frame.push_back(rand_octet());

        cut = frame.size();
        if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(1, frame.size());
        send_frame(frame, cut);
    endfunction

    // Loose octets with random end marks, to knock the parser off alignment.
    function automatic void queue_noise();
        repeat ($urandom_range(1, 4)) push_octet(rand_octet(), $urandom_range(0, 3) == 0);
    endfunction

    // Write one register while the parser is idle and mirror it in the shadow copy.
    task automatic write_reg(input logic [sdp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            sdp_pkg::CFG_EXPECTED_CODING:    coding_ref     = value;
            sdp_pkg::CFG_MAX_CENTER_OCTETS:  center_max_ref = value[3:0];
            sdp_pkg::CFG_MAX_ADDRESS_DIGITS: addr_max_ref   = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every octet is taken and every field has come back,
    // then let the parser settle.
    task automatic wait_idle();
        while (taken_cnt != queued_cnt || field_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One random phase under one register setting.
    task automatic run_phase(input logic [7:0] coding, input logic [3:0] center_max,
                             input logic [4:0] addr_max, input logic calm);
        int unsigned start;
        write_reg(sdp_pkg::CFG_EXPECTED_CODING, coding);
        write_reg(sdp_pkg::CFG_MAX_CENTER_OCTETS, {4'd0, center_max});
        write_reg(sdp_pkg::CFG_MAX_ADDRESS_DIGITS, {3'd0, addr_max});
        // Fill the queue away from the falling edge, where the driver pops it.
        @(posedge clk);
        steady = calm;
        start  = queued_cnt;
        while (queued_cnt - start < PHASE_OCTETS)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_noise();
            queue_pdu();
        end
        wait_idle();
        steady <= 1'b0;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, driver and monitors
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Byte driver: change inputs on the falling edge, hold an offered octet
    // until it is taken, and idle at random unless the phase runs steady.
    always @(negedge clk)
    begin : drive_octets
        pdu_octet_t nxt;
        if (!rst_n)
        begin
            pdu_in_if.valid <= 1'b0;
        end
        else if (!pdu_in_if.valid || took_octet)
        begin
            if (octet_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = octet_q.pop_front();
                pdu_in_if.valid      <= 1'b1;
                pdu_in_if.pdu_byte   <= nxt.octet;
                pdu_in_if.end_of_pdu <= nxt.eop;
            end
            else
            begin
                pdu_in_if.valid <= 1'b0;
            end
        end
        // Stall the field sink at random as well.
        field_out_if.ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // Input monitor: every accepted octet advances the predictor.
    always @(posedge clk)
    begin
        took_octet <= rst_n && pdu_in_if.valid && pdu_in_if.ready;
        if (rst_n && pdu_in_if.valid && pdu_in_if.ready)
        begin
            parse_octet(pdu_in_if.pdu_byte, pdu_in_if.end_of_pdu);
            taken_cnt++;
        end
    end

    // Output monitor: compare each accepted field with the oldest expectation.
    always @(posedge clk)
    begin : check_fields
        sdp_pkg::result_t want;
        if (rst_n && field_out_if.valid && field_out_if.ready)
        begin
            if (field_expect_q.size() == 0)
            begin
                $error("unexpected field: kind %0d value %0d",
                       field_out_if.field_kind, field_out_if.field_value);
                failed = 1'b1;
            end
            else
            begin
                want = field_expect_q.pop_front();
                check_field("field_kind", 32'(want.field_kind),
                            32'(field_out_if.field_kind));
                check_field("field_value", 32'(want.field_value),
                            32'(field_out_if.field_value));
                check_field("digit_position", 32'(want.digit_position),
                            32'(field_out_if.digit_position));
                check_field("error_code", 32'(want.error_code),
                            32'(field_out_if.error_code));
                check_field("coding_matches", 32'(want.coding_matches),
                            32'(field_out_if.coding_matches));
                check_field("last", 32'(want.last), 32'(field_out_if.last));
            end
        end
    end

    // Watchdog on a hung handshake.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_sms_deliver_pdu_field_parser_core NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : run_test
        logic [7:0] frame[$];

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        pdu_in_if.valid         = 1'b0;
        pdu_in_if.pdu_byte      = '0;
        pdu_in_if.end_of_pdu    = 1'b0;
        field_out_if.ready      = 1'b0;
        steady                  = 1'b0;
        failed                  = 1'b0;
        took_octet              = 1'b0;
        queued_cnt              = 0;
        taken_cnt               = 0;
        cycle_cnt               = 0;
        coding_ref              = sdp_pkg::EXPECTED_CODING_RST;
        center_max_ref          = sdp_pkg::MAX_CENTER_OCTETS_RST;
        addr_max_ref            = sdp_pkg::MAX_ADDRESS_DIGITS_RST;
        clear_frame();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset register values.
        // Centre length too big, end mark lands in the skip phase.
        frame = {8'hFF, 8'h00};
        send_frame(frame, frame.size());
        // Centre digits with filler, then an address length one over the limit.
        frame = {8'h03, 8'h91, 8'h21, 8'hF3, 8'h00, 8'h0D, 8'h12};
        send_frame(frame, frame.size());
        // Bad high nibble, then a low nibble of F (not filler) that ends the PDU itself.
        frame = {8'h02, 8'h81, 8'hA1, 8'h77};
        send_frame(frame, frame.size());
        frame = {8'h02, 8'h81, 8'h1F};
        send_frame(frame, frame.size());
        // Absent centre, UDHI set, header longer than UDL (saturates to zero),
        // end mark inside the header.
        frame = {8'h00, 8'h40, 8'h03, 8'h91, 8'h21, 8'hF3, 8'h00, 8'h04,
                 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F,
                 8'h02, 8'h05, 8'hEE};
        send_frame(frame, frame.size());
        // Centre type only, empty address, DCS mismatch, payload past UDL.
        frame = {8'h01, 8'h91, 8'h00, 8'h00, 8'h81, 8'h7F, 8'hFF,
                 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE,
                 8'h00, 8'hFF, 8'h80};
        send_frame(frame, frame.size());
        wait_idle();

        // Random phases: defaults, both extremes, random settings (one of them with no
        // idling on either side), then the widest centre limit with a zero address limit.
        run_phase(sdp_pkg::EXPECTED_CODING_RST, sdp_pkg::MAX_CENTER_OCTETS_RST,
                  sdp_pkg::MAX_ADDRESS_DIGITS_RST, 1'b0);
        run_phase(8'h00, 4'd0, 5'd0, 1'b0);
        run_phase(8'hFF, 4'd15, 5'd24, 1'b0);
        run_phase(rand_octet(), 4'($urandom_range(0, 15)), 5'($urandom_range(0, 24)), 1'b1);
        run_phase(rand_octet(), 4'($urandom_range(0, 15)), 5'($urandom_range(0, 24)), 1'b0);
        run_phase(sdp_pkg::EXPECTED_CODING_RST, 4'd15, 5'd0, 1'b0);

        if (!failed)
            $display("tb_sms_deliver_pdu_field_parser_core OK");
        else
            $display("tb_sms_deliver_pdu_field_parser_core NOT OK");
        $finish;
    end

endmodule
